/* rtl/fsoh_pkg.sv */
// Shared widths, codes, state type and control structs of the first-seen ordered histogram.
package fsoh_pkg;

    localparam int VAL_W  = 10;
    localparam int TOT_W  = 11;
    localparam int OCC_W  = 16;
    localparam int MODE_W = 2;

    localparam int VAL_SPAN = 2 ** VAL_W;

    localparam int VALUE_RANGE_DEF = 1024;
    localparam int COUNT_BITS_DEF  = 16;

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOOKUP,
        S_UPDATE,
        S_FETCH,
        S_CLEAR,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic lookup;
        logic update;
        logic fetch;
        logic sweep;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic              in_valid;
        logic [MODE_W-1:0] in_mode;
        logic [MODE_W-1:0] mode;
        logic              sweep_last;
        logic              out_free;
    } t_ctrl_status;

endpackage

/* rtl/fsoh_if.sv */
// Valid/ready channel interfaces for the command and result transfers.
interface fsoh_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [fsoh_pkg::MODE_W-1:0] mode;
    logic [fsoh_pkg::VAL_W-1:0]  sample_value;
    logic [fsoh_pkg::VAL_W-1:0]  position;

    modport source (output valid, output mode, output sample_value, output position,
                    input ready);
    modport sink (input valid, input mode, input sample_value, input position,
                  output ready);
endinterface

interface fsoh_res_if;
    logic                       valid;
    logic                       ready;
    logic [fsoh_pkg::VAL_W-1:0]  entry_value;
    logic [fsoh_pkg::OCC_W-1:0]  occurrences;
    logic [fsoh_pkg::TOT_W-1:0]  distinct_total;
    logic                       was_new;
    logic                       entry_valid;

    modport source (output valid, output entry_value, output occurrences,
                    output distinct_total, output was_new, output entry_valid,
                    input ready);
    modport sink (input valid, input entry_value, input occurrences,
                  input distinct_total, input was_new, input entry_valid,
                  output ready);
endinterface

/* rtl/first_seen_ordered_histogram_core.sv */
// Top level of the first-seen ordered histogram: controller, datapath and checks.
// The block handles one command at a time and returns exactly one result per command.
// An add passes through the lookup and update states before its result, and a read adds a fetch
// state, because it chains two registered memory accesses (order list, then count); an unused
// mode goes straight to its result. After reset, and for each clear command, the count memory
// (min(VALUE_RANGE, 1024) entries) is swept one entry per cycle with no command accepted; a clear
// command then returns its all-zero result. A finished result waits in the output register,
// and the next command is accepted while it does.
module first_seen_ordered_histogram_core #(
    parameter int VALUE_RANGE = fsoh_pkg::VALUE_RANGE_DEF,
    parameter int COUNT_BITS  = fsoh_pkg::COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fsoh_cmd_if.sink   i_cmd,
    fsoh_res_if.source o_res
);

    fsoh_pkg::t_ctrl_cmd    w_cmd;
    fsoh_pkg::t_ctrl_status w_status;

    fsoh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    fsoh_dp #(
        .VALUE_RANGE (VALUE_RANGE),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_ctl (w_cmd),
        .o_status  (w_status),
        .i_cmd     (i_cmd),
        .o_res     (o_res)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("A second command was accepted while one is in progress.");

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sweep |-> !i_cmd.ready)
        else $error("A command was offered ready during the clearing sweep.");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_status.out_free)
        else $error("The output register was loaded while holding an untaken result.");

    a_result_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_res.valid)
        else $error("A loaded result did not appear on the result channel.");

endmodule

/* rtl/fsoh_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module fsoh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fsoh_ctrl.sv */
// Controller state machine that sequences lookups, updates, clearing sweeps and result hand-off.
module fsoh_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fsoh_pkg::t_ctrl_status i_status,
    output fsoh_pkg::t_ctrl_cmd    o_cmd
);

    fsoh_pkg::t_state r_state;
    fsoh_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsoh_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fsoh_pkg::S_INIT: begin
                if (i_status.sweep_last) begin
                    n_state = fsoh_pkg::S_IDLE;
                end
            end
            fsoh_pkg::S_IDLE: begin
                if (i_status.in_valid) begin
                    case (i_status.in_mode)
                        fsoh_pkg::MODE_ADD:   n_state = fsoh_pkg::S_LOOKUP;
                        fsoh_pkg::MODE_READ:  n_state = fsoh_pkg::S_LOOKUP;
                        fsoh_pkg::MODE_CLEAR: n_state = fsoh_pkg::S_CLEAR;
                        default:              n_state = fsoh_pkg::S_RESULT;
                    endcase
                end
            end
            fsoh_pkg::S_LOOKUP: begin
                n_state = fsoh_pkg::S_UPDATE;
            end
            fsoh_pkg::S_UPDATE: begin
                if (i_status.mode == fsoh_pkg::MODE_READ) begin
                    n_state = fsoh_pkg::S_FETCH;
                end else begin
                    n_state = fsoh_pkg::S_RESULT;
                end
            end
            fsoh_pkg::S_FETCH: begin
                n_state = fsoh_pkg::S_RESULT;
            end
            fsoh_pkg::S_CLEAR: begin
                if (i_status.sweep_last) begin
                    n_state = fsoh_pkg::S_RESULT;
                end
            end
            fsoh_pkg::S_RESULT: begin
                if (i_status.out_free) begin
                    n_state = fsoh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fsoh_pkg::S_INIT;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            fsoh_pkg::S_INIT:   o_cmd.sweep    = 1'b1;
            fsoh_pkg::S_IDLE:   o_cmd.in_ready = 1'b1;
            fsoh_pkg::S_LOOKUP: o_cmd.lookup   = 1'b1;
            fsoh_pkg::S_UPDATE: o_cmd.update   = 1'b1;
            fsoh_pkg::S_FETCH:  o_cmd.fetch    = 1'b1;
            fsoh_pkg::S_CLEAR:  o_cmd.sweep    = 1'b1;
            fsoh_pkg::S_RESULT: o_cmd.load_out = i_status.out_free;
            default:            o_cmd          = '0;
        endcase
    end

endmodule

/* rtl/fsoh_dp.sv */
// Datapath with the count and order memories, distinct counter, sweep counter and result registers.
module fsoh_dp #(
    parameter int VALUE_RANGE = fsoh_pkg::VALUE_RANGE_DEF,
    parameter int COUNT_BITS  = fsoh_pkg::COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fsoh_pkg::t_ctrl_cmd    i_cmd_ctl,
    output fsoh_pkg::t_ctrl_status o_status,
    fsoh_cmd_if.sink               i_cmd,
    fsoh_res_if.source             o_res
);

    localparam int VAL_W  = fsoh_pkg::VAL_W;
    localparam int TOT_W  = fsoh_pkg::TOT_W;
    localparam int OCC_W  = fsoh_pkg::OCC_W;
    localparam int MODE_W = fsoh_pkg::MODE_W;
    localparam int DEPTH  = (VALUE_RANGE < fsoh_pkg::VAL_SPAN) ? VALUE_RANGE
                                                               : fsoh_pkg::VAL_SPAN;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam bit ALL_IN = (VALUE_RANGE >= fsoh_pkg::VAL_SPAN);
    localparam logic [VAL_W-1:0] RANGE_LIM = VAL_W'(VALUE_RANGE);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [TOT_W-1:0] DEPTH_T   = TOT_W'(DEPTH);

    logic [MODE_W-1:0]     r_mode;
    logic [VAL_W-1:0]      r_val;
    logic [VAL_W-1:0]      r_pos;
    logic [TOT_W-1:0]      r_distinct;
    logic [AW-1:0]         r_sweep;

    logic [VAL_W-1:0]      r_res_ev;
    logic [OCC_W-1:0]      r_res_occ;
    logic [TOT_W-1:0]      r_res_total;
    logic                  r_res_nw;
    logic                  r_res_vld;

    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_out_ev;
    logic [OCC_W-1:0]      r_out_occ;
    logic [TOT_W-1:0]      r_out_total;
    logic                  r_out_nw;
    logic                  r_out_vld;

    logic                  w_accept;
    logic                  w_is_add;
    logic                  w_is_read;
    logic                  w_in_range;
    logic                  w_do_add;
    logic                  w_new;
    logic                  w_pos_ok;
    logic                  w_out_free;
    logic [COUNT_BITS-1:0] w_count;
    logic [COUNT_BITS-1:0] w_count_next;
    logic [VAL_W-1:0]      w_order;

    logic                  w_cnt_we;
    logic [AW-1:0]         w_cnt_waddr;
    logic [COUNT_BITS-1:0] w_cnt_wdata;
    logic [AW-1:0]         w_cnt_raddr;
    logic                  w_ord_we;

    assign i_cmd.ready  = i_cmd_ctl.in_ready;
    assign w_accept     = i_cmd.valid && i_cmd_ctl.in_ready;
    assign w_is_add     = (r_mode == fsoh_pkg::MODE_ADD);
    assign w_is_read    = (r_mode == fsoh_pkg::MODE_READ);
    assign w_in_range   = ALL_IN || (r_val < RANGE_LIM);
    assign w_do_add     = i_cmd_ctl.update && w_is_add && w_in_range;
    assign w_new        = (w_count == '0);
    assign w_count_next = (&w_count) ? w_count : w_count + COUNT_BITS'(1);
    assign w_pos_ok     = (TOT_W'(r_pos) < r_distinct);
    assign w_out_free   = !r_out_valid || o_res.ready;

    assign w_cnt_we    = i_cmd_ctl.sweep || w_do_add;
    assign w_cnt_waddr = i_cmd_ctl.sweep ? r_sweep : r_val[AW-1:0];
    assign w_cnt_wdata = i_cmd_ctl.sweep ? '0 : w_count_next;
    assign w_cnt_raddr = i_cmd_ctl.lookup ? r_val[AW-1:0] : w_order[AW-1:0];
    assign w_ord_we    = w_do_add && w_new && (r_distinct < DEPTH_T);

    fsoh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_re    (i_cmd_ctl.lookup || i_cmd_ctl.update),
        .i_raddr (w_cnt_raddr),
        .o_rdata (w_count)
    );

    fsoh_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (w_ord_we),
        .i_waddr (r_distinct[AW-1:0]),
        .i_wdata (r_val),
        .i_re    (i_cmd_ctl.lookup),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (w_order)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distinct  <= '0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd_ctl.sweep) begin
                r_sweep    <= (r_sweep == LAST_ADDR) ? '0 : r_sweep + AW'(1);
                r_distinct <= '0;
            end else if (w_do_add && w_new) begin
                r_distinct <= r_distinct + TOT_W'(1);
            end
            if (i_cmd_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode      <= i_cmd.mode;
            r_val       <= i_cmd.sample_value;
            r_pos       <= i_cmd.position;
            r_res_ev    <= '0;
            r_res_occ   <= '0;
            r_res_total <= (i_cmd.mode == fsoh_pkg::MODE_CLEAR) ? '0 : r_distinct;
            r_res_nw    <= 1'b0;
            r_res_vld   <= 1'b0;
        end
        if (i_cmd_ctl.update && w_is_add) begin
            r_res_ev <= r_val;
            if (w_in_range) begin
                r_res_occ   <= OCC_W'(w_count_next);
                r_res_nw    <= w_new;
                r_res_total <= r_distinct + TOT_W'(w_new);
            end
        end
        if (i_cmd_ctl.update && w_is_read) begin
            r_res_vld <= w_pos_ok;
            r_res_ev  <= w_pos_ok ? w_order : '0;
        end
        if (i_cmd_ctl.fetch) begin
            r_res_occ <= r_res_vld ? OCC_W'(w_count) : '0;
        end
        if (i_cmd_ctl.load_out) begin
            r_out_ev    <= r_res_ev;
            r_out_occ   <= r_res_occ;
            r_out_total <= r_res_total;
            r_out_nw    <= r_res_nw;
            r_out_vld   <= r_res_vld;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.entry_value    = r_out_ev;
    assign o_res.occurrences    = r_out_occ;
    assign o_res.distinct_total = r_out_total;
    assign o_res.was_new        = r_out_nw;
    assign o_res.entry_valid    = r_out_vld;

    assign o_status.in_valid   = i_cmd.valid;
    assign o_status.in_mode    = i_cmd.mode;
    assign o_status.mode       = r_mode;
    assign o_status.sweep_last = (r_sweep == LAST_ADDR);
    assign o_status.out_free   = w_out_free;

endmodule
